[rtl/cc20_pkg.sv]
// Shared types, constants and round functions for the ChaCha block generator.
// No dependencies.
package cc20_pkg;

   localparam int unsigned DEFAULT_DOUBLE_ROUNDS = 10;
   localparam int unsigned NUM_PAIRS             = 8;
   localparam int unsigned PAIR_IDX_W            = 3;
   localparam int unsigned CSR_INDEX_W           = 3;
   localparam int unsigned CSR_DATA_W            = 64;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_0    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_1    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_2    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_3    = 3'd4;

   // "expand 32-byte k" / "expand 16-byte k"
   localparam logic [31:0] SIGMA_0     = 32'h6170_7865;
   localparam logic [31:0] SIGMA_1_256 = 32'h3320_646e;
   localparam logic [31:0] SIGMA_2_256 = 32'h7962_2d32;
   localparam logic [31:0] SIGMA_1_128 = 32'h3120_646e;
   localparam logic [31:0] SIGMA_2_128 = 32'h7962_2d36;
   localparam logic [31:0] SIGMA_3     = 32'h6b20_6574;

   localparam logic [4:0] ROT_A = 5'd16;
   localparam logic [4:0] ROT_B = 5'd12;
   localparam logic [4:0] ROT_C = 5'd8;
   localparam logic [4:0] ROT_D = 5'd7;

   typedef logic [15:0][31:0] state_type;

   typedef struct packed {
      logic [63:0] nonce_high;
      logic [63:0] nonce_low;
   } req_type;

   typedef struct packed {
      logic [63:0]           keystream_pair;
      logic [PAIR_IDX_W-1:0] pair_index;
      logic                  last_pair;
   } rsp_type;

   function automatic logic [31:0] rotl(logic [31:0] v, logic [4:0] n);
      return (v << n) | (v >> (6'd32 - {1'b0, n}));
   endfunction

   function automatic state_type init_state(logic mode, logic [63:0] k0, logic [63:0] k1,
                                            logic [63:0] k2, logic [63:0] k3, req_type nonce);
      state_type   s;
      logic [63:0] hk0;
      logic [63:0] hk1;
      hk0   = mode ? k2 : k0;
      hk1   = mode ? k3 : k1;
      s[0]  = SIGMA_0;
      s[1]  = mode ? SIGMA_1_256 : SIGMA_1_128;
      s[2]  = mode ? SIGMA_2_256 : SIGMA_2_128;
      s[3]  = SIGMA_3;
      s[4]  = k0[31:0];
      s[5]  = k0[63:32];
      s[6]  = k1[31:0];
      s[7]  = k1[63:32];
      s[8]  = hk0[31:0];
      s[9]  = hk0[63:32];
      s[10] = hk1[31:0];
      s[11] = hk1[63:32];
      s[12] = nonce.nonce_low[31:0];
      s[13] = nonce.nonce_low[63:32];
      s[14] = nonce.nonce_high[31:0];
      s[15] = nonce.nonce_high[63:32];
      return s;
   endfunction

   // Half of a half-round: two add/xor/rotate steps on all four quarter-rounds.
   // diag picks the diagonal lanes, second picks the 8/7 rotations.
   function automatic state_type half_step(state_type s, logic diag, logic second);
      state_type  r;
      logic [1:0] off;
      logic [1:0] lane;
      logic [3:0] a;
      logic [3:0] b;
      logic [3:0] c;
      logic [3:0] d;
      logic [4:0] ra;
      logic [4:0] rb;
      r   = s;
      off = {1'b0, diag};
      ra  = second ? ROT_C : ROT_A;
      rb  = second ? ROT_D : ROT_B;
      for (int i = 0; i < 4; i++) begin
         lane = 2'(i);
         a    = {2'b00, lane};
         b    = {2'b01, 2'(lane + off)};
         c    = {2'b10, 2'(lane + off + off)};
         d    = {2'b11, 2'(lane + off + off + off)};
         r[a] = r[a] + r[b];
         r[d] = rotl(r[d] ^ r[a], ra);
         r[c] = r[c] + r[d];
         r[b] = rotl(r[b] ^ r[c], rb);
      end
      return r;
   endfunction

endpackage

[rtl/chacha20_block_generator_core.sv]
// ChaCha block generator top level: pipelined rounds and result serialiser.
// Depends on cc20_pkg.
//
// Usage: configure the key mode and key words through the csr_ port while the
// block is idle (write enable, register index, 64-bit data; no read-back).
// An item, a 128-bit counter/nonce on req_data, is taken at a clock edge where
// start is high and busy is low. Each item produces eight result beats on
// rsp_data, marked by rsp_valid for one cycle each, in pair order 0 to 7, with
// last_pair set on the eighth.
// The first beat passes through stage 0, the round stages, the serialiser and
// the result register; beats then follow on consecutive cycles. Input spacing
// is set by the eight-beat result port: after each accept, busy holds off new
// items until its counter runs down. The round pipeline has one stage per two
// add/xor/rotate steps (4*DOUBLE_ROUNDS stages) and holds several items.
// Reset clears the pipeline valid bits, the serialiser and the key registers
// (mode returns to 256-bit). The receiver cannot stall; beats are never held.
module chacha20_block_generator_core #(
   parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DEFAULT_DOUBLE_ROUNDS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  cc20_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output cc20_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [cc20_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cc20_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import cc20_pkg::*;

   localparam int unsigned NUM_STEPS = 4 * DOUBLE_ROUNDS;
   localparam logic [PAIR_IDX_W-1:0] LAST_IDX = PAIR_IDX_W'(NUM_PAIRS - 1);

   // configuration
   logic        key_mode_ff;
   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff <= 1'b1;
         key0_ff     <= '0;
         key1_ff     <= '0;
         key2_ff     <= '0;
         key3_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_KEY_MODE: key_mode_ff <= csr_wdata[0];
            REG_KEY_0:    key0_ff     <= csr_wdata;
            REG_KEY_1:    key1_ff     <= csr_wdata;
            REG_KEY_2:    key2_ff     <= csr_wdata;
            REG_KEY_3:    key3_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input spacing: one beat in, then hold off until the serialiser can keep up
   logic [PAIR_IDX_W-1:0] gap_ff, gap_in;
   logic                  accept;

   assign busy   = (gap_ff != '0);
   assign accept = start && !busy;

   always_comb begin
      gap_in = gap_ff;
      if (accept)
         gap_in = LAST_IDX;
      else if (gap_ff != '0)
         gap_in = gap_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         gap_ff <= '0;
      else
         gap_ff <= gap_in;
   end

   // round pipeline; stage 0 holds the initial state
   state_type            st_ff    [0:NUM_STEPS];
   req_type              nonce_ff [0:NUM_STEPS];
   logic [NUM_STEPS:0]   vld_ff;

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff[0] <= 1'b0;
      else
         vld_ff[0] <= accept;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st_ff[0]    <= init_state(key_mode_ff, key0_ff, key1_ff, key2_ff, key3_ff, req_data);
         nonce_ff[0] <= req_data;
      end
   end

   for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
      localparam logic DIAG   = 1'((k / 2) % 2);
      localparam logic SECOND = 1'(k % 2);
      state_type st_in;

      assign st_in = half_step(st_ff[k], DIAG, SECOND);

      always_ff @(posedge clock) begin
         if (reset)
            vld_ff[k+1] <= 1'b0;
         else
            vld_ff[k+1] <= vld_ff[k];
      end

      always_ff @(posedge clock) begin
         st_ff[k+1]    <= st_in;
         nonce_ff[k+1] <= nonce_ff[k];
      end
   end

   // feed-forward add; the key must be held stable while items are in flight (the block does not enforce this)
   state_type init_last, blk_in;

   always_comb begin
      init_last = init_state(key_mode_ff, key0_ff, key1_ff, key2_ff, key3_ff,
                             nonce_ff[NUM_STEPS]);
      for (int i = 0; i < 16; i++)
         blk_in[i] = st_ff[NUM_STEPS][i] + init_last[i];
   end

   // serialiser: shifts one pair out per cycle
   logic                  load;
   state_type             ser_ff, ser_in;
   logic                  active_ff, active_in;
   logic [PAIR_IDX_W-1:0] idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   assign load = vld_ff[NUM_STEPS];

   always_comb begin
      ser_in       = ser_ff;
      active_in    = active_ff && (idx_ff != LAST_IDX);
      idx_in       = idx_ff + 1'b1;
      rsp_valid_in = active_ff;
      rsp_in       = rsp_ff;
      if (active_ff) begin
         rsp_in.keystream_pair = {ser_ff[1], ser_ff[0]};
         rsp_in.pair_index     = idx_ff;
         rsp_in.last_pair      = (idx_ff == LAST_IDX);
         ser_in                = ser_ff >> 64;
      end
      if (load) begin
         ser_in    = blk_in;
         active_in = 1'b1;
         idx_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ser_ff <= ser_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a new block never lands on the serialiser mid-burst
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!active_ff || idx_ff == LAST_IDX))
      else $error("block arrived while serialiser still busy");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_pair) |=>
         (rsp_valid && rsp_data.pair_index == $past(rsp_data.pair_index) + 1'b1))
      else $error("result burst broken");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_pair == (rsp_data.pair_index == LAST_IDX)))
      else $error("last_pair out of step with pair_index");

endmodule
